// ===== rtl/tacpg_pkg.sv =====
// Package for the two-axis cascaded PID gimbal controller.
// Holds widths, register indexes and shared types; depends on nothing.
`timescale 1ns / 1ps
package tacpg_pkg;
  localparam int SigW  = 16;
  localparam int AccW  = 48;
  localparam int CfgW  = 48;
  localparam int IdxW  = 3;

  localparam logic [IdxW-1:0] REG_YAW_POS   = 3'd0;
  localparam logic [IdxW-1:0] REG_PITCH_POS = 3'd1;
  localparam logic [IdxW-1:0] REG_YAW_RATE  = 3'd2;
  localparam logic [IdxW-1:0] REG_PITCH_RATE = 3'd3;
  localparam logic [IdxW-1:0] REG_YAW_OFS   = 3'd4;
  localparam logic [IdxW-1:0] REG_PITCH_OFS = 3'd5;
  localparam logic [IdxW-1:0] REG_LIMIT     = 3'd6;
  localparam logic [IdxW-1:0] REG_MISS_LIM  = 3'd7;

  typedef struct packed {
    logic signed [SigW-1:0] yaw_angle_sample;
    logic                   yaw_sample_fresh;
    logic signed [SigW-1:0] pitch_angle_sample;
    logic                   pitch_sample_fresh;
    logic signed [SigW-1:0] gyro_rate_y;
    logic signed [SigW-1:0] gyro_rate_z;
    logic signed [SigW-1:0] yaw_attitude_cmd;
    logic signed [SigW-1:0] pitch_attitude_cmd;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] yaw_drive;
    logic signed [15:0] pitch_drive;
    logic               yaw_lost;
    logic               pitch_lost;
  } out_item_t;

  // Serial multiply-accumulate control.
  typedef struct packed {
    logic start;
    logic busy;
  } mac_ctl_t;

  function automatic logic signed [SigW-1:0] sat_sig(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'((64'sd1 <<< (SigW - 1)) - 64'sd1);
    lo = -hi - AccW'(1);
    if (v > hi) sat_sig = hi[SigW-1:0];
    else if (v < lo) sat_sig = lo[SigW-1:0];
    else sat_sig = v[SigW-1:0];
  endfunction
endpackage

// ===== rtl/tacpg_if.sv =====
// Valid/ready channel interface carrying one packed payload.
// Depends on tacpg_pkg for the payload types and is compiled after it.
`timescale 1ns / 1ps
interface tacpg_in_if;
  logic valid;
  logic ready;
  tacpg_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tacpg_out_if;
  logic valid;
  logic ready;
  tacpg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tacpg_mac.sv =====
// Bit-serial signed multiply-accumulate: acc + gain * err, one shift-add step per multiplier bit.
// Depends on tacpg_pkg.
`timescale 1ns / 1ps
module tacpg_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tacpg_pkg::mac_ctl_t                   ctl_in,
  input  logic signed [17:0]                    gain_in,
  input  logic signed [tacpg_pkg::SigW-1:0]     err_in,
  input  logic signed [tacpg_pkg::AccW+1:0]     acc_in,
  output logic signed [tacpg_pkg::AccW+1:0]     acc_out,
  output logic                                  done_out
);
  localparam int AW = tacpg_pkg::AccW + 2;
  localparam int Steps = tacpg_pkg::SigW;
  localparam int CntW = $clog2(Steps + 1);

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [tacpg_pkg::SigW-1:0] mul_r, mul_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [AW-1:0] addend_r, addend_nxt;
  logic done_r, done_nxt;

  // The multiplier bits shift out LSB first; the top bit has negative weight.
  always_comb begin
    cnt_nxt = cnt_r;
    mul_nxt = mul_r;
    acc_nxt = acc_r;
    addend_nxt = addend_r;
    done_nxt = 1'b0;
    if (ctl_in.start) begin
      cnt_nxt = CntW'(Steps);
      mul_nxt = err_in;
      acc_nxt = acc_in;
      addend_nxt = AW'(gain_in);
    end else if (cnt_r != '0) begin
      if (mul_r[0]) begin
        if (cnt_r == CntW'(1)) acc_nxt = acc_r - addend_r;
        else acc_nxt = acc_r + addend_r;
      end
      mul_nxt = mul_r >> 1;
      addend_nxt = addend_r <<< 1;
      cnt_nxt = cnt_r - CntW'(1);
      done_nxt = (cnt_r == CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      done_r <= done_nxt;
    end
    mul_r <= mul_nxt;
    acc_r <= acc_nxt;
    addend_r <= addend_nxt;
  end

  assign acc_out = acc_r;
  assign done_out = done_r;

  a_done_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cnt_r) == CntW'(1)) else $error("mac done without last step");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_in.start |-> cnt_r == '0) else $error("mac restarted while busy");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && !ctl_in.start) |=> cnt_r == $past(cnt_r) - CntW'(1))
    else $error("mac count slip");
endmodule

// ===== rtl/two_axis_cascaded_pid_gimbal.sv =====
// Two-axis cascaded PID gimbal controller.
// Input channel in_ (tacpg_in_if sink): one control tick per request, carrying
// both encoder angles with fresh flags, both gyro rates and both attitude commands.
// Output channel out_ (tacpg_out_if source): one request per tick with both
// clamped drives and the sticky lost flags.
// Configuration: cfg_we, cfg_idx, cfg_data write register cfg_idx at a clock
// edge; the user must write only while the block is idle; the block does not enforce it.
// Each tick runs ten serial multiply-accumulate passes (three per attitude loop,
// two per rate loop) on a single shift-add unit. A pass starts the unit, runs
// sixteen shift-add steps and hands back the sum. Each axis adds an error step
// and two loop update steps, and the tick ends with an output step.
// One tick is worked at a time; the next is accepted once the result register is
// empty or being taken.
// The result waits in an output register while the receiver stalls; the block
// holds its state and takes no new tick until the result is taken.
// Reset (rst_n low, synchronous) clears the loop accumulators, error history,
// held angles, miss counters and lost flags and loads the register defaults.
`timescale 1ns / 1ps
module two_axis_cascaded_pid_gimbal (
  input  logic                          clk,
  input  logic                          rst_n,
  tacpg_in_if.sink                      in_ch,
  tacpg_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [tacpg_pkg::IdxW-1:0]    cfg_idx,
  input  logic [tacpg_pkg::CfgW-1:0]    cfg_data
);
  localparam int SW = tacpg_pkg::SigW;
  localparam int AW = tacpg_pkg::AccW;
  localparam int XW = AW + 2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ERR   = 4'd1;
  localparam logic [3:0] ST_MAC   = 4'd2;
  localparam logic [3:0] ST_WAIT  = 4'd3;
  localparam logic [3:0] ST_LOOP  = 4'd4;
  localparam logic [3:0] ST_OUT   = 4'd5;

  logic [47:0] pg_r [2];
  logic [31:0] rg_r [2];
  logic signed [SW-1:0] ofs_r [2];
  logic [14:0] lim_r;
  logic [7:0] mlim_r;

  logic signed [SW-1:0] held_r [2];
  logic [7:0] miss_r [2];
  logic [1:0] lost_r;
  logic signed [SW-1:0] e1_r [4];
  logic signed [SW-1:0] e2_r [4];
  logic signed [AW-1:0] acc_r [4];

  tacpg_pkg::in_item_t item_r;
  logic [3:0] st_r;
  logic [1:0] loop_r;   // 0 yaw pos, 1 yaw rate, 2 pitch pos, 3 pitch rate
  logic [1:0] term_r;   // which of e, e1, e2
  logic signed [SW-1:0] e_r;
  logic signed [XW-1:0] sum_r;
  logic signed [15:0] drv_r [2];
  logic out_valid_r;
  tacpg_pkg::out_item_t out_r;

  tacpg_pkg::mac_ctl_t mac_ctl;
  logic signed [17:0] mac_gain;
  logic signed [SW-1:0] mac_err;
  logic signed [XW-1:0] mac_acc;
  logic signed [XW-1:0] mac_res;
  logic mac_done;

  logic axis_sel;
  logic pos_loop;
  logic [1:0] slot;
  logic signed [17:0] kp, ki, kd, a0, a1, a2;
  logic signed [SW+1:0] err_raw;
  logic signed [SW:0] rate_raw;
  logic signed [XW-1:0] acc_sat;
  logic signed [AW-9:0] spd_shift;
  logic signed [AW-21:0] drv_shift;
  logic signed [15:0] drv_clamp;
  logic signed [SW-1:0] spd;
  logic accept;

  assign axis_sel = loop_r[1];
  assign pos_loop = ~loop_r[0];
  assign slot = {loop_r[0], loop_r[1]}; // acc/history slot: position loops 0 and 1, rate loops 2 and 3, by axis
  assign accept = in_ch.valid & in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) & (~out_valid_r | out_ch.ready);

  always_comb begin
    if (pos_loop) begin
      kp = 18'(signed'(pg_r[axis_sel][15:0]));
      ki = 18'(signed'(pg_r[axis_sel][31:16]));
      kd = 18'(signed'(pg_r[axis_sel][47:32]));
    end else begin
      kp = 18'(signed'(rg_r[axis_sel][15:0]));
      ki = 18'(signed'(rg_r[axis_sel][31:16]));
      kd = '0;
    end
    a0 = kp + ki + kd;
    a1 = -kp - (kd <<< 1);
    a2 = kd;
    case (term_r)
      2'd0: begin mac_gain = a0; mac_err = e_r; end
      2'd1: begin mac_gain = a1; mac_err = e1_r[slot]; end
      default: begin mac_gain = a2; mac_err = e2_r[slot]; end
    endcase
  end

  // Error of the current loop.
  always_comb begin
    if (!axis_sel)
      err_raw = (SW+2)'(item_r.yaw_attitude_cmd) + (SW+2)'(ofs_r[0]) - (SW+2)'(held_r[0]);
    else
      err_raw = (SW+2)'(item_r.pitch_attitude_cmd) + (SW+2)'(ofs_r[1])
                - (SW+2)'(held_r[1]);
    rate_raw = (SW+1)'(spd) - (SW+1)'(axis_sel ? item_r.gyro_rate_y : item_r.gyro_rate_z);
  end

  always_comb begin
    if (sum_r > XW'(48'sh7FFF_FFFF_FFFF)) acc_sat = XW'(48'sh7FFF_FFFF_FFFF);
    else if (sum_r < -XW'(48'sh7FFF_FFFF_FFFF) - XW'(1))
      acc_sat = -XW'(48'sh7FFF_FFFF_FFFF) - XW'(1);
    else acc_sat = sum_r;
    spd_shift = acc_sat[AW-1:8];
    drv_shift = acc_sat[AW-1:20];
    spd = tacpg_pkg::sat_sig(AW'(spd_shift));
    if (drv_shift > (AW-20)'(signed'({1'b0, lim_r}))) drv_clamp = signed'({1'b0, lim_r});
    else if (drv_shift < -(AW-20)'(signed'({1'b0, lim_r})))
      drv_clamp = -signed'({1'b0, lim_r});
    else drv_clamp = drv_shift[15:0];
  end

  assign mac_ctl.start = (st_r == ST_MAC);
  assign mac_ctl.busy = (st_r == ST_WAIT);
  assign mac_acc = sum_r;

  tacpg_mac u_mac (
    .clk(clk), .rst_n(rst_n), .ctl_in(mac_ctl), .gain_in(mac_gain),
    .err_in(mac_err), .acc_in(mac_acc), .acc_out(mac_res), .done_out(mac_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_r[0] <= '0; pg_r[1] <= '0; rg_r[0] <= '0; rg_r[1] <= '0;
      ofs_r[0] <= '0; ofs_r[1] <= '0;
      lim_r <= 15'd5000; mlim_r <= 8'd100;
      held_r[0] <= '0; held_r[1] <= '0; miss_r[0] <= '0; miss_r[1] <= '0;
      lost_r <= '0;
      for (int i = 0; i < 4; i++) begin
        e1_r[i] <= '0; e2_r[i] <= '0; acc_r[i] <= '0;
      end
      st_r <= ST_IDLE; out_valid_r <= 1'b0;
      loop_r <= '0; term_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          tacpg_pkg::REG_YAW_POS:    pg_r[0] <= cfg_data;
          tacpg_pkg::REG_PITCH_POS:  pg_r[1] <= cfg_data;
          tacpg_pkg::REG_YAW_RATE:   rg_r[0] <= cfg_data[31:0];
          tacpg_pkg::REG_PITCH_RATE: rg_r[1] <= cfg_data[31:0];
          tacpg_pkg::REG_YAW_OFS:    ofs_r[0] <= cfg_data[15:0];
          tacpg_pkg::REG_PITCH_OFS:  ofs_r[1] <= cfg_data[15:0];
          tacpg_pkg::REG_LIMIT:      lim_r <= cfg_data[14:0];
          tacpg_pkg::REG_MISS_LIM:   mlim_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (st_r == ST_OUT && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (accept) begin
            // Latch angles and count misses per axis.
            if (in_ch.data.yaw_sample_fresh) begin
              held_r[0] <= in_ch.data.yaw_angle_sample; miss_r[0] <= 8'd1;
            end else if ({1'b0, miss_r[0]} + 9'd1 > {1'b0, mlim_r}) begin
              lost_r[0] <= 1'b1; miss_r[0] <= 8'd1;
            end else miss_r[0] <= miss_r[0] + 8'd1;
            if (in_ch.data.pitch_sample_fresh) begin
              held_r[1] <= in_ch.data.pitch_angle_sample; miss_r[1] <= 8'd1;
            end else if ({1'b0, miss_r[1]} + 9'd1 > {1'b0, mlim_r}) begin
              lost_r[1] <= 1'b1; miss_r[1] <= 8'd1;
            end else miss_r[1] <= miss_r[1] + 8'd1;
            item_r <= in_ch.data;
            loop_r <= '0;
            st_r <= ST_ERR;
          end
        end
        ST_ERR: begin
          e_r <= tacpg_pkg::sat_sig(AW'(err_raw));
          sum_r <= XW'(acc_r[slot]);
          term_r <= '0;
          st_r <= ST_MAC;
        end
        ST_MAC: st_r <= ST_WAIT;
        ST_WAIT: begin
          if (mac_done) begin
            sum_r <= mac_res;
            if (term_r == (pos_loop ? 2'd2 : 2'd1)) st_r <= ST_LOOP;
            else begin
              term_r <= term_r + 2'd1;
              st_r <= ST_MAC;
            end
          end
        end
        ST_LOOP: begin
          acc_r[slot] <= acc_sat[AW-1:0];
          e2_r[slot] <= e1_r[slot];
          e1_r[slot] <= e_r;
          if (pos_loop) begin
            // Speed command minus gyro rate becomes the rate loop error.
            e_r <= tacpg_pkg::sat_sig(AW'(rate_raw));
            sum_r <= XW'(acc_r[{1'b1, axis_sel}]);
            loop_r <= loop_r + 2'd1;
            term_r <= '0;
            st_r <= ST_MAC;
          end else begin
            drv_r[axis_sel] <= drv_clamp;
            if (axis_sel) st_r <= ST_OUT;
            else begin
              loop_r <= 2'd2;
              st_r <= ST_ERR;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r.yaw_drive <= drv_r[0];
            out_r.pitch_drive <= drv_r[1];
            out_r.yaw_lost <= lost_r[0];
            out_r.pitch_lost <= lost_r[1];
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !in_ch.ready) else $error("ready while working");
  a_lost_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(lost_r[0]) |-> lost_r[0]) else $error("yaw lost flag cleared");
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_OUT) else $error("result without work");
endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the two-axis cascaded PID gimbal controller.
// Drives control-tick requests, predicts each result in place and compares.
// Depends on tacpg_pkg, the channel interfaces and the controller RTL.
`timescale 1ns / 1ps
module tb_top;
  localparam longint AccMax = 64'sh7FFFFFFFFFFF;
  localparam longint AccMin = -AccMax - 1;
  localparam int DirRows = 16;

  // One directed row: the request, and a typed-in result where it is obvious.
  typedef struct {
    tacpg_pkg::in_item_t  tick;
    bit                   known;
    tacpg_pkg::out_item_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tacpg_pkg::IdxW-1:0] cfg_idx;
  logic [tacpg_pkg::CfgW-1:0] cfg_data;

  tacpg_in_if  in_ch();
  tacpg_out_if out_ch();

  two_axis_cascaded_pid_gimbal dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Predictor state and register copy.
  logic [47:0] pos_gain [2];
  logic [31:0] rate_gain [2];
  longint zero_ofs [2];
  longint lim;
  int unsigned miss_lim;
  longint held [2];
  int unsigned misses [2];
  bit lost [2];
  longint hist [8];
  longint acc [4];

  tacpg_pkg::out_item_t drive_q [$];
  int errors;
  bit hold_off;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint gain_of(logic [47:0] p, int k);
    logic signed [15:0] g;
    g = p[16*k +: 16];
    return longint'(g);
  endfunction

  function automatic longint pid_update(int n, longint kp, longint ki, longint kd,
                                        longint e);
    longint a;
    a = acc[n] + (kp + ki + kd) * e + (-kp - 2 * kd) * hist[2*n] + kd * hist[2*n+1];
    if (a > AccMax) a = AccMax;
    if (a < AccMin) a = AccMin;
    acc[n] = a;
    hist[2*n+1] = hist[2*n];
    hist[2*n] = e;
    return a;
  endfunction

  function automatic void latch_angle(int ax, logic fresh, logic signed [15:0] s);
    int unsigned c;
    if (fresh) begin
      held[ax] = longint'(s);
      misses[ax] = 1;
    end else begin
      c = (misses[ax] & 8'hFF) + 1;
      if (c > miss_lim) begin
        lost[ax] = 1'b1;
        c = 1;
      end
      misses[ax] = c & 8'hFF;
    end
  endfunction

  function automatic logic signed [15:0] axis_drive(int ax, longint cmd, longint gyro);
    longint e, spd, er, d;
    e = sat16(cmd + zero_ofs[ax] - held[ax]);
    spd = sat16(floor_shift(pid_update(ax, gain_of(pos_gain[ax], 0),
                gain_of(pos_gain[ax], 1), gain_of(pos_gain[ax], 2), e), 8));
    er = sat16(spd - gyro);
    d = floor_shift(pid_update(ax + 2, gain_of({16'd0, rate_gain[ax]}, 0),
                gain_of({16'd0, rate_gain[ax]}, 1), 0, er), 20);
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return d[15:0];
  endfunction

  function automatic tacpg_pkg::out_item_t predict_tick(tacpg_pkg::in_item_t t);
    tacpg_pkg::out_item_t r;
    latch_angle(0, t.yaw_sample_fresh, t.yaw_angle_sample);
    latch_angle(1, t.pitch_sample_fresh, t.pitch_angle_sample);
    r.yaw_drive = axis_drive(0, longint'(t.yaw_attitude_cmd), longint'(t.gyro_rate_z));
    r.pitch_drive = axis_drive(1, longint'(t.pitch_attitude_cmd), longint'(t.gyro_rate_y));
    r.yaw_lost = lost[0];
    r.pitch_lost = lost[1];
    return r;
  endfunction

  function automatic void model_reset();
    pos_gain[0] = '0; pos_gain[1] = '0;
    rate_gain[0] = '0; rate_gain[1] = '0;
    zero_ofs[0] = 0; zero_ofs[1] = 0;
    lim = 5000; miss_lim = 100;
    held[0] = 0; held[1] = 0;
    misses[0] = 0; misses[1] = 0;
    lost[0] = 0; lost[1] = 0;
    foreach (hist[i]) hist[i] = 0;
    foreach (acc[i]) acc[i] = 0;
  endfunction

  // Deasserts the write and lets the clock run idle before returning, so that the next drive starts cleanly.
  task automatic write_reg(logic [tacpg_pkg::IdxW-1:0] idx, logic [tacpg_pkg::CfgW-1:0] v);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      tacpg_pkg::REG_YAW_POS:    pos_gain[0] = v[47:0];
      tacpg_pkg::REG_PITCH_POS:  pos_gain[1] = v[47:0];
      tacpg_pkg::REG_YAW_RATE:   rate_gain[0] = v[31:0];
      tacpg_pkg::REG_PITCH_RATE: rate_gain[1] = v[31:0];
      tacpg_pkg::REG_YAW_OFS:    zero_ofs[0] = longint'($signed(v[15:0]));
      tacpg_pkg::REG_PITCH_OFS:  zero_ofs[1] = longint'($signed(v[15:0]));
      tacpg_pkg::REG_LIMIT:      lim = longint'(v[14:0]);
      tacpg_pkg::REG_MISS_LIM:   miss_lim = 32'(v[7:0]);
      default: ;
    endcase
  endtask

  task automatic send_tick(tacpg_pkg::in_item_t t, bit known, tacpg_pkg::out_item_t res);
    int gap;
    tacpg_pkg::out_item_t p;
    gap = $urandom_range(0, 5);
    // The first edge separates this request from the previous deassertion.
    @(posedge clk);
    repeat (gap) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    p = predict_tick(t);
    if (known && p != res) begin
      $display("%0t table row disagrees: expected %h, predicted %h", $time, res, p);
      errors++;
    end
    drive_q.push_back(p);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (drive_q.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (250) @(posedge clk);
  endtask

  function automatic tacpg_pkg::in_item_t rand_tick(int fresh_pct);
    tacpg_pkg::in_item_t t;
    t.yaw_angle_sample = 16'($urandom);
    t.pitch_angle_sample = 16'($urandom);
    t.yaw_sample_fresh = $urandom_range(0, 99) < fresh_pct;
    t.pitch_sample_fresh = $urandom_range(0, 99) < fresh_pct;
    t.gyro_rate_y = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                    16'($signed($urandom_range(0, 800)) - 400);
    t.gyro_rate_z = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                    16'($signed($urandom_range(0, 800)) - 400);
    t.yaw_attitude_cmd = 16'($urandom);
    t.pitch_attitude_cmd = 16'($urandom);
    return t;
  endfunction

  function automatic logic [tacpg_pkg::CfgW-1:0] rand_gains(int nk);
    logic [tacpg_pkg::CfgW-1:0] g;
    g = '0;
    for (int k = 0; k < nk; k++)
      g[16*k +: 16] = $urandom_range(0, 7) == 0 ? 16'($urandom) :
                      16'($signed($urandom_range(0, 1024)) - 512);
    return g;
  endfunction

  // Result side: random stalls, one long hold-off while requests keep coming.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_ch.data);
        errors++;
      end else begin
        tacpg_pkg::out_item_t e;
        e = drive_q.pop_front();
        if (out_ch.data.yaw_drive !== e.yaw_drive) begin
          $display("%0t yaw_drive expected %0d actual %0d", $time, e.yaw_drive,
                   out_ch.data.yaw_drive);
          errors++;
        end
        if (out_ch.data.pitch_drive !== e.pitch_drive) begin
          $display("%0t pitch_drive expected %0d actual %0d", $time, e.pitch_drive,
                   out_ch.data.pitch_drive);
          errors++;
        end
        if (out_ch.data.yaw_lost !== e.yaw_lost) begin
          $display("%0t yaw_lost expected %b actual %b", $time, e.yaw_lost,
                   out_ch.data.yaw_lost);
          errors++;
        end
        if (out_ch.data.pitch_lost !== e.pitch_lost) begin
          $display("%0t pitch_lost expected %b actual %b", $time, e.pitch_lost,
                   out_ch.data.pitch_lost);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    row_t rows [DirRows];
    tacpg_pkg::out_item_t z;
    tacpg_pkg::in_item_t t;
    errors = 0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With zero gains every drive is zero; only the flags move.
    z = '0;
    for (int i = 0; i < DirRows; i++) begin
      rows[i].tick = '0;
      rows[i].known = 1'b0;
      rows[i].res = z;
    end
    rows[0].known = 1'b1;
    rows[1].tick = '{16'sh7FFF, 1'b1, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000,
                     16'sh8000, 16'sh7FFF};
    rows[1].known = 1'b1;
    rows[2].tick = '{16'sh8000, 1'b1, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh7FFF,
                     16'sh7FFF, 16'sh8000};
    rows[2].known = 1'b1;
    for (int i = 3; i < DirRows; i++) rows[i].tick = rand_tick(50);
    foreach (rows[i]) send_tick(rows[i].tick, rows[i].known, rows[i].res);
    drain();

    // Missed-sample limit of one: yaw lost on the first stale tick.
    write_reg(tacpg_pkg::REG_MISS_LIM, 48'd1);
    write_reg(tacpg_pkg::REG_YAW_POS, 48'd0);
    t = '0;
    t.pitch_sample_fresh = 1'b1;
    repeat (3) send_tick(t, 1'b0, z);
    drain();

    // Extreme gains, offsets and limits, then random phases.
    write_reg(tacpg_pkg::REG_YAW_POS, 48'h7FFF_7FFF_7FFF);
    write_reg(tacpg_pkg::REG_PITCH_POS, 48'h8000_8000_8000);
    write_reg(tacpg_pkg::REG_YAW_RATE, 48'h7FFF_7FFF);
    write_reg(tacpg_pkg::REG_PITCH_RATE, 48'h8000_8000);
    write_reg(tacpg_pkg::REG_YAW_OFS, 48'h7FFF);
    write_reg(tacpg_pkg::REG_PITCH_OFS, 48'h8000);
    write_reg(tacpg_pkg::REG_LIMIT, 48'h7FFF);
    write_reg(tacpg_pkg::REG_MISS_LIM, 48'd255);
    for (int i = 0; i < 6; i++) send_tick(rand_tick(50), 1'b0, z);
    drain();
    write_reg(tacpg_pkg::REG_LIMIT, 48'd0);
    send_tick(rand_tick(50), 1'b0, z);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(tacpg_pkg::REG_YAW_POS, rand_gains(3));
      write_reg(tacpg_pkg::REG_PITCH_POS, rand_gains(3));
      write_reg(tacpg_pkg::REG_YAW_RATE, rand_gains(2));
      write_reg(tacpg_pkg::REG_PITCH_RATE, rand_gains(2));
      write_reg(tacpg_pkg::REG_YAW_OFS, 48'($urandom));
      write_reg(tacpg_pkg::REG_PITCH_OFS, 48'($urandom));
      write_reg(tacpg_pkg::REG_LIMIT, ph == 0 ? 48'h7FFF : 48'($urandom_range(0, 32767)));
      write_reg(tacpg_pkg::REG_MISS_LIM, ph == 1 ? 48'd255 : 48'($urandom_range(1, 20)));
      if (ph == 2) hold_off = 1'b1;
      for (int i = 0; i < 200; i++)
        send_tick(rand_tick(ph == 3 ? 5 : 70), 1'b0, z);
      drain();
    end

    if (errors == 0 && drive_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/tacpg_pkg.sv
rtl/tacpg_if.sv
rtl/tacpg_mac.sv
rtl/two_axis_cascaded_pid_gimbal.sv
tb/tb_top.sv
